### hw/rtl/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg: shared constants for the square crop-and-scale address block
// Field widths, clamp limits, fixed-point widths and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package scsa_pkg;

    localparam int MAX_DIM = 4096;
    localparam int MAX_OUT = 256;

    localparam int COL_W  = 8;
    localparam int SRC_W  = 24;
    localparam int DEST_W = 16;
    localparam int DIM_W  = 13;
    localparam int CRN_W  = 12;
    localparam int OUT_W  = 9;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Q.1 corner width, Q12.16 step width, divider quotient width
    localparam int Q1_W   = 16;
    localparam int STEP_W = $clog2(MAX_DIM) + 16;
    localparam int QUO_W  = STEP_W + 2;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_OUT_SIZE     = 3'd2;
    localparam logic [2:0] REG_BOX_PRESENT  = 3'd3;
    localparam logic [2:0] REG_BOX_LEFT     = 3'd4;
    localparam logic [2:0] REG_BOX_BOTTOM   = 3'd5;
    localparam logic [2:0] REG_BOX_RIGHT    = 3'd6;
    localparam logic [2:0] REG_BOX_TOP      = 3'd7;

endpackage

`default_nettype wire

### hw/rtl/scsa_if.sv
// ----------------------------------------------------------------------------
// scsa_if: valid/ready channels of the square crop-and-scale address block
// Coordinate channel in, address result channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsa_coord_if;
    import scsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [COL_W-1:0] out_row;

    modport source (output valid, output out_col, output out_row, input ready);
    modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface scsa_result_if;
    import scsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [SRC_W-1:0]  source_index;
    logic [DEST_W-1:0] dest_index;
    logic              copy_pixel;

    modport source (output valid, output source_index, output dest_index,
                    output copy_pixel, input ready);
    modport sink   (input valid, input source_index, input dest_index,
                    input copy_pixel, output ready);
endinterface

`default_nettype wire

### hw/rtl/square_crop_scale_address.sv
// ----------------------------------------------------------------------------
// square_crop_scale_address: nearest-neighbor square crop-and-scale addresses
// One output pixel coordinate in, one source/destination address word out.
//
// coord carries (out_col, out_row); result carries source_index, dest_index
// and copy_pixel. A word is moved when valid and ready are both high.
// Registers are written over the APB port; pready is always high.
// An accepted coord word passes through six registered stages to result.
// One word per cycle is sustained while result is ready and the block is
// out of its setup pass; the multiplies sit in stages 2 and 5.
// After reset and after every register write the block runs a setup pass
// (4 squaring stages, one load, 30 steps of the radix-2 step divider) with
// coord.ready low; register writes are still taken.
// When result is stalled, each stage holds its word and empty stages ahead
// of it keep filling, so outside setup coord.ready drops only when full.
// ----------------------------------------------------------------------------
`default_nettype none

module square_crop_scale_address (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [scsa_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [scsa_pkg::DATA_W-1:0]   pwdata,
    output logic      [scsa_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    scsa_coord_if.sink                         coord,
    scsa_result_if.source                      result
);
    import scsa_pkg::*;

    localparam logic [1:0] ST_SETUP = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [2:0]       SETUP_LAST = 3'd4;
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return v;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input logic [OUT_W-1:0] v);
        if (v == '0)
            return OUT_W'(1);
        else if (v > OUT_W'(MAX_OUT))
            return OUT_W'(MAX_OUT);
        else
            return v;
    endfunction

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic             cfg_write;
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [OUT_W-1:0] out_size_reg;
    logic             box_present_reg;
    logic [CRN_W-1:0] box_left_reg;
    logic [CRN_W-1:0] box_bottom_reg;
    logic [CRN_W-1:0] box_right_reg;
    logic [CRN_W-1:0] box_top_reg;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(4096);
            image_height_reg <= DIM_W'(4096);
            out_size_reg     <= OUT_W'(64);
            box_present_reg  <= 1'b0;
            box_left_reg     <= '0;
            box_bottom_reg   <= '0;
            box_right_reg    <= '0;
            box_top_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_OUT_SIZE:     out_size_reg     <= pwdata[OUT_W-1:0];
                REG_BOX_PRESENT:  box_present_reg  <= pwdata[0];
                REG_BOX_LEFT:     box_left_reg     <= pwdata[CRN_W-1:0];
                REG_BOX_BOTTOM:   box_bottom_reg   <= pwdata[CRN_W-1:0];
                REG_BOX_RIGHT:    box_right_reg    <= pwdata[CRN_W-1:0];
                REG_BOX_TOP:      box_top_reg      <= pwdata[CRN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_reg);
            REG_OUT_SIZE:     prdata = DATA_W'(out_size_reg);
            REG_BOX_PRESENT:  prdata = DATA_W'(box_present_reg);
            REG_BOX_LEFT:     prdata = DATA_W'(box_left_reg);
            REG_BOX_BOTTOM:   prdata = DATA_W'(box_bottom_reg);
            REG_BOX_RIGHT:    prdata = DATA_W'(box_right_reg);
            REG_BOX_TOP:      prdata = DATA_W'(box_top_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // setup pipe: clamp and squarify the box (runs every cycle)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]       wi_c_reg, hi_c_reg, glim_reg;
    logic [OUT_W-1:0]       n_c_reg;
    logic                   xwide_reg;
    logic [DIM_W-1:0]       d_reg;
    logic [CRN_W-1:0]       glo_reg, ghi_reg, flo_reg, fhi_reg;

    logic signed [DIM_W-1:0] dx, dy;
    logic signed [DIM_W:0]   dd;
    logic                    xwide;
    logic [DIM_W-1:0]        wi_c, hi_c;

    assign wi_c  = clamp_dim(image_width_reg);
    assign hi_c  = clamp_dim(image_height_reg);
    assign dx    = $signed({1'b0, box_right_reg}) - $signed({1'b0, box_left_reg});
    assign dy    = $signed({1'b0, box_top_reg}) - $signed({1'b0, box_bottom_reg});
    assign xwide = dx > dy;
    assign dd    = xwide ? ($signed({dx[DIM_W-1], dx}) - $signed({dy[DIM_W-1], dy}))
                         : ($signed({dy[DIM_W-1], dy}) - $signed({dx[DIM_W-1], dx}));

    always_ff @(posedge clk)
    begin
        wi_c_reg  <= wi_c;
        hi_c_reg  <= hi_c;
        n_c_reg   <= clamp_out(out_size_reg);
        xwide_reg <= xwide;
        d_reg     <= dd[DIM_W-1:0];
        glo_reg   <= xwide ? box_bottom_reg : box_left_reg;
        ghi_reg   <= xwide ? box_top_reg    : box_right_reg;
        glim_reg  <= xwide ? hi_c           : wi_c;
        flo_reg   <= xwide ? box_left_reg   : box_bottom_reg;
        fhi_reg   <= xwide ? box_right_reg  : box_top_reg;
    end

    // grow the short side; clamp at the near edge
    logic signed [Q1_W-1:0] g0_reg, g1_reg;
    logic signed [Q1_W-1:0] g0_b, g1_b;
    logic [CRN_W+1:0]       ghi_d;

    assign ghi_d = {2'b0, ghi_reg} + {1'b0, d_reg};

    always_comb
    begin
        g0_b = $signed({3'b0, glo_reg, 1'b0}) - $signed({3'b0, d_reg});
        g1_b = $signed({3'b0, ghi_reg, 1'b0}) + $signed({3'b0, d_reg});
        if (g0_b < 0)
        begin
            g0_b = '0;
            g1_b = $signed({1'b0, ghi_d, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        g0_reg <= g0_b;
        g1_reg <= g1_b;
    end

    // clamp at the far edge; map back to x and y
    logic signed [Q1_W-1:0] c0x_reg, c1x_reg, c0y_reg, c1y_reg;
    logic signed [Q1_W-1:0] g0_c, g1_c, lim2;

    assign lim2 = $signed({2'b0, glim_reg, 1'b0});

    always_comb
    begin
        g0_c = g0_reg;
        g1_c = g1_reg;
        if (g1_reg >= lim2)
        begin
            g1_c = lim2 - Q1_W'(2);
            g0_c = $signed({3'b0, glo_reg, 1'b0}) - $signed({2'b0, d_reg, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (xwide_reg)
        begin
            c0x_reg <= $signed({3'b0, flo_reg, 1'b0});
            c1x_reg <= $signed({3'b0, fhi_reg, 1'b0});
            c0y_reg <= g0_c;
            c1y_reg <= g1_c;
        end
        else
        begin
            c0x_reg <= g0_c;
            c1x_reg <= g1_c;
            c0y_reg <= $signed({3'b0, flo_reg, 1'b0});
            c1y_reg <= $signed({3'b0, fhi_reg, 1'b0});
        end
    end

    // derived per-item constants
    logic signed [Q1_W-1:0] size2_reg, basey_reg, c0x_d_reg;
    logic [CRN_W-1:0]       c1xh_reg, c1yh_reg;

    always_ff @(posedge clk)
    begin
        size2_reg <= c1y_reg - c0y_reg;
        basey_reg <= $signed({3'b0, hi_c_reg}) - (c0y_reg >>> 1);
        c0x_d_reg <= c0x_reg;
        c1xh_reg  <= c1x_reg[CRN_W:1];
        c1yh_reg  <= c1y_reg[CRN_W:1];
    end

    // ------------------------------------------------------------------
    // setup sequencer and radix-2 step divider
    // ------------------------------------------------------------------
    logic [1:0]       state_reg, state_next;
    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_load, div_run, div_done;

    logic [OUT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [OUT_W:0]    div_sh;
    logic              div_ge;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        div_load   = 1'b0;
        div_run    = 1'b0;
        div_done   = 1'b0;
        case (state_reg)
            ST_SETUP:
            begin
                if (phase_reg == SETUP_LAST)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    div_load   = 1'b1;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_DIV:
            begin
                div_run = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_RUN;
                    div_done   = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RUN: ;
            default:
            begin
                state_next = ST_SETUP;
                phase_next = '0;
            end
        endcase
        if (cfg_write)
        begin
            state_next = ST_SETUP;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SETUP;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign div_sh   = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge   = div_sh >= {1'b0, n_c_reg};
    assign rem_next = div_ge ? OUT_W'(div_sh - {1'b0, n_c_reg}) : div_sh[OUT_W-1:0];
    assign quo_next = {quo_reg[QUO_W-2:0], div_ge};

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            rem_reg <= '0;
            quo_reg <= (size2_reg > 0) ? {size2_reg[Q1_W-2:0], 15'b0} : '0;
        end
        else if (div_run)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (div_done)
            step_reg <= (quo_next[QUO_W-1:STEP_W] != '0) ? STEP_MAX
                                                         : quo_next[STEP_W-1:0];
    end

    // ------------------------------------------------------------------
    // item pipeline
    // ------------------------------------------------------------------
    localparam int PROD_W = STEP_W + COL_W;
    localparam int CX_W   = PROD_W + 3;
    localparam int XI_W   = CX_W - 16;

    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, ov_reg;

    assign en6 = !ov_reg || result.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign coord.ready = en1 && (state_reg == ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= coord.valid && coord.ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) ov_reg <= v5_reg;
        end
    end

    // stage 1: grid check
    logic [COL_W-1:0] s1_col_reg, s1_row_reg, s1_nm1r_reg;
    logic             s1_grid_reg;
    logic [OUT_W-1:0] nm1r_full;

    assign nm1r_full = n_c_reg - OUT_W'(1) - {1'b0, coord.out_row};

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_col_reg  <= coord.out_col;
            s1_row_reg  <= coord.out_row;
            s1_grid_reg <= ({1'b0, coord.out_col} < n_c_reg)
                        && ({1'b0, coord.out_row} < n_c_reg);
            s1_nm1r_reg <= nm1r_full[COL_W-1:0];
        end
    end

    // stage 2: multiplies
    logic [COL_W-1:0]       s2_col_reg;
    logic                   s2_grid_reg;
    logic [PROD_W-1:0]      s2_stepcol_reg, s2_steprow_reg;
    logic [COL_W+OUT_W-1:0] s2_dmul_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_col_reg     <= s1_col_reg;
            s2_grid_reg    <= s1_grid_reg;
            s2_stepcol_reg <= step_reg * s1_col_reg;
            s2_steprow_reg <= step_reg * s1_row_reg;
            s2_dmul_reg    <= s1_nm1r_reg * n_c_reg;
        end
    end

    // stage 3: scaled coordinates in Q.16, destination address
    logic signed [CX_W-1:0] s3_cx_reg, s3_cy_reg;
    logic                   s3_grid_reg;
    logic [DEST_W-1:0]      s3_dest_reg;
    logic [COL_W+OUT_W-1:0] dest_sum;

    assign dest_sum = s2_dmul_reg + {{OUT_W{1'b0}}, s2_col_reg};

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_cx_reg   <= $signed({{(CX_W-Q1_W-15){c0x_d_reg[Q1_W-1]}}, c0x_d_reg, 15'b0})
                         + $signed({3'b0, s2_stepcol_reg});
            s3_cy_reg   <= $signed({{(CX_W-Q1_W-16){basey_reg[Q1_W-1]}}, basey_reg, 16'b0})
                         - $signed({3'b0, s2_steprow_reg});
            s3_grid_reg <= s2_grid_reg;
            s3_dest_reg <= s2_grid_reg ? dest_sum[DEST_W-1:0] : '0;
        end
    end

    // stage 4: truncate toward zero
    logic signed [XI_W-1:0] s4_xi_reg, s4_yi_reg;
    logic                   s4_grid_reg;
    logic [DEST_W-1:0]      s4_dest_reg;
    logic                   cx_fix, cy_fix;

    assign cx_fix = s3_cx_reg[CX_W-1] && (s3_cx_reg[15:0] != '0);
    assign cy_fix = s3_cy_reg[CX_W-1] && (s3_cy_reg[15:0] != '0);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_xi_reg   <= s3_cx_reg[CX_W-1:16] + XI_W'(cx_fix);
            s4_yi_reg   <= s3_cy_reg[CX_W-1:16] + XI_W'(cy_fix);
            s4_grid_reg <= s3_grid_reg;
            s4_dest_reg <= s3_dest_reg;
        end
    end

    // stage 5: box and image checks, row multiply
    logic [CRN_W-1:0]       s5_xi_reg;
    logic [CRN_W+DIM_W-1:0] s5_prod_reg;
    logic                   s5_copy_reg;
    logic [DEST_W-1:0]      s5_dest_reg;
    logic signed [XI_W-1:0] hmy;
    logic                   in_box, in_img;

    assign hmy    = $signed({{(XI_W-DIM_W){1'b0}}, hi_c_reg}) - s4_yi_reg;
    assign in_box = (s4_xi_reg < $signed({{(XI_W-CRN_W){1'b0}}, c1xh_reg}))
                 && (hmy < $signed({{(XI_W-CRN_W){1'b0}}, c1yh_reg}));
    assign in_img = !s4_xi_reg[XI_W-1] && !s4_yi_reg[XI_W-1]
                 && (s4_xi_reg < $signed({{(XI_W-DIM_W){1'b0}}, wi_c_reg}))
                 && (s4_yi_reg < $signed({{(XI_W-DIM_W){1'b0}}, hi_c_reg}));

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_xi_reg   <= s4_xi_reg[CRN_W-1:0];
            s5_prod_reg <= s4_yi_reg[CRN_W-1:0] * wi_c_reg;
            s5_copy_reg <= s4_grid_reg && box_present_reg && in_box && in_img;
            s5_dest_reg <= s4_dest_reg;
        end
    end

    // stage 6: output register
    logic [SRC_W-1:0]       o_source_reg;
    logic [DEST_W-1:0]      o_dest_reg;
    logic                   o_copy_reg;
    logic [CRN_W+DIM_W-1:0] src_sum;

    assign src_sum = s5_prod_reg + {{DIM_W{1'b0}}, s5_xi_reg};

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            o_source_reg <= s5_copy_reg ? src_sum[SRC_W-1:0] : '0;
            o_dest_reg   <= s5_dest_reg;
            o_copy_reg   <= s5_copy_reg;
        end
    end

    assign result.valid        = ov_reg;
    assign result.source_index = o_source_reg;
    assign result.dest_index   = o_dest_reg;
    assign result.copy_pixel   = o_copy_reg;

`ifndef SYNTH
    a_write_restarts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> state_reg == ST_SETUP)
        else $error("register write did not restart setup");

    a_divider_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (cnt_reg == DIV_LAST) && !cfg_write
        |=> state_reg == ST_RUN)
        else $error("step divider did not finish");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        coord.valid && coord.ready |=> v1_reg)
        else $error("accepted word missing from stage 1");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && !en6 |=> v5_reg)
        else $error("stalled word lost in stage 5");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for square_crop_scale_address
// Drives output pixel coordinates over the coord channel and checks every
// address word on the result channel against a built-in predictor of the
// squarified crop, Q12.16 step and truncated source position (typed rows:
// their own expected word). Registers are set over APB between phases;
// random idling on both sides, and one long receiver hold to fill the pipe.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int END_WAIT       = 20;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 108;
    localparam int PRESSURE_PHASE = 8;
    localparam longint STEP_LIM   = longint'(MAX_DIM) * 65536 - 1;

    typedef struct packed {
        logic [SRC_W-1:0]  source_index;
        logic [DEST_W-1:0] dest_index;
        logic              copy_pixel;
    } addr_word_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [OUT_W-1:0] size;
        logic             present;
        logic [CRN_W-1:0] left;
        logic [CRN_W-1:0] bottom;
        logic [CRN_W-1:0] right;
        logic [CRN_W-1:0] top;
    } crop_cfg_t;

    typedef struct packed {
        logic [2:0]       cfg_sel;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic             typed;
        addr_word_t       want;
    } stim_row_t;

    // cfg_sel 0 is the reset setting; typed rows carry their own expected word
    localparam stim_row_t DIRECTED_ROWS [0:23] = '{
        '{3'd0, 8'd0,   8'd0,   1'b1, '{24'd0, 16'd4032, 1'b0}},
        '{3'd0, 8'd63,  8'd0,   1'b1, '{24'd0, 16'd4095, 1'b0}},
        '{3'd0, 8'd63,  8'd63,  1'b1, '{24'd0, 16'd63,   1'b0}},
        '{3'd0, 8'd64,  8'd0,   1'b1, '{24'd0, 16'd0,    1'b0}},
        '{3'd0, 8'd0,   8'd64,  1'b1, '{24'd0, 16'd0,    1'b0}},
        '{3'd0, 8'd255, 8'd255, 1'b1, '{24'd0, 16'd0,    1'b0}},
        '{3'd0, 8'd170, 8'd85,  1'b1, '{24'd0, 16'd0,    1'b0}},
        '{3'd1, 8'd0,   8'd0,   1'b0, '0},
        '{3'd1, 8'd255, 8'd255, 1'b0, '0},
        '{3'd1, 8'd255, 8'd0,   1'b0, '0},
        '{3'd1, 8'd0,   8'd255, 1'b0, '0},
        '{3'd1, 8'd128, 8'd127, 1'b0, '0},
        '{3'd2, 8'd0,   8'd0,   1'b0, '0},
        '{3'd2, 8'd50,  8'd50,  1'b0, '0},
        '{3'd2, 8'd99,  8'd99,  1'b0, '0},
        '{3'd3, 8'd0,   8'd0,   1'b0, '0},
        '{3'd3, 8'd99,  8'd0,   1'b0, '0},
        '{3'd3, 8'd50,  8'd50,  1'b0, '0},
        '{3'd4, 8'd0,   8'd0,   1'b0, '0},
        '{3'd4, 8'd31,  8'd31,  1'b0, '0},
        '{3'd5, 8'd0,   8'd0,   1'b0, '0},
        '{3'd5, 8'd1,   8'd0,   1'b1, '{24'd0, 16'd0,    1'b0}},
        '{3'd6, 8'd255, 8'd255, 1'b0, '0},
        '{3'd6, 8'd0,   8'd0,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    scsa_coord_if  coord_ch ();
    scsa_result_if result_ch ();

    square_crop_scale_address dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coord   (coord_ch),
        .result  (result_ch)
    );

    crop_cfg_t  cfg_now;
    addr_word_t pending_addrs [$];
    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint eff_dim(input longint v, input longint hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic addr_word_t crop_scale_addr(input logic [COL_W-1:0] c,
                                                   input logic [COL_W-1:0] r);
        longint w, h, n, col, row, lx, by, rx, ty, dx, dy, d;
        longint c0x, c0y, c1x, c1y, size2, step, cx, cy, xi, yi;
        bit hit;
        addr_word_t res;
        res = '0;
        w = eff_dim(cfg_now.width, MAX_DIM);
        h = eff_dim(cfg_now.height, MAX_DIM);
        n = eff_dim(cfg_now.size, MAX_OUT);
        col = c;
        row = r;
        if (col >= n || row >= n)
            return res;
        res.dest_index = DEST_W'(col + (n - 1 - row) * n);
        if (!cfg_now.present)
            return res;
        lx = cfg_now.left;
        by = cfg_now.bottom;
        rx = cfg_now.right;
        ty = cfg_now.top;
        dx = rx - lx;
        dy = ty - by;
        if (dx > dy)
        begin
            d = dx - dy;
            c0x = 2 * lx;
            c1x = 2 * rx;
            c0y = 2 * by - d;
            c1y = 2 * ty + d;
            if (c0y < 0)
            begin
                c0y = 0;
                c1y = 2 * (ty + d);
            end
            if (c1y >= 2 * h)
            begin
                c1y = 2 * (h - 1);
                c0y = 2 * (by - d);
            end
        end
        else
        begin
            d = dy - dx;
            c0y = 2 * by;
            c1y = 2 * ty;
            c0x = 2 * lx - d;
            c1x = 2 * rx + d;
            if (c0x < 0)
            begin
                c0x = 0;
                c1x = 2 * (rx + d);
            end
            if (c1x >= 2 * w)
            begin
                c1x = 2 * (w - 1);
                c0x = 2 * (lx - d);
            end
        end
        size2 = c1y - c0y;
        if (size2 <= 0)
            step = 0;
        else
        begin
            step = (size2 * 32768) / n;
            if (step > STEP_LIM)
                step = STEP_LIM;
        end
        cx = c0x * 32768 + step * col;
        xi = cx / 65536;
        cy = (h - c0y / 2) * 65536 - step * row;
        yi = cy / 65536;
        hit = (xi < c1x / 2) && ((h - yi) < c1y / 2);
        if (xi < 0 || yi < 0 || xi >= w || yi >= h)
            hit = 1'b0;
        if (hit)
        begin
            res.source_index = SRC_W'(xi + yi * w);
            res.copy_pixel = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(MAX_DIM);
            3: return DIM_W'($urandom_range(8191, MAX_DIM + 1));
            4: return DIM_W'($urandom_range(64, 2));
            default: return DIM_W'($urandom_range(MAX_DIM, 16));
        endcase
    endfunction

    function automatic crop_cfg_t random_crop();
        crop_cfg_t c;
        int ew, eh;
        c.width = pick_dim();
        c.height = pick_dim();
        case ($urandom_range(7))
            0: c.size = '0;
            1: c.size = OUT_W'($urandom_range(511, MAX_OUT + 1));
            2: c.size = OUT_W'(MAX_OUT);
            3: c.size = OUT_W'(1);
            default: c.size = OUT_W'($urandom_range(MAX_OUT, 2));
        endcase
        c.present = ($urandom_range(9) != 0);
        ew = int'(eff_dim(c.width, MAX_DIM));
        eh = int'(eff_dim(c.height, MAX_DIM));
        if ($urandom_range(5) == 0)
        begin
            c.left = CRN_W'($urandom);
            c.bottom = CRN_W'($urandom);
            c.right = CRN_W'($urandom);
            c.top = CRN_W'($urandom);
        end
        else
        begin
            c.left = CRN_W'($urandom_range(ew - 1));
            c.right = CRN_W'($urandom_range(ew - 1, int'(c.left)));
            c.bottom = CRN_W'($urandom_range(eh - 1));
            c.top = CRN_W'($urandom_range(eh - 1, int'(c.bottom)));
        end
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // called in the step of the last accepted word; waits for the pipe to drain
    task automatic load_crop(input crop_cfg_t c);
        coord_ch.valid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge clk);
        write_reg(REG_IMAGE_WIDTH, DATA_W'(c.width));
        write_reg(REG_IMAGE_HEIGHT, DATA_W'(c.height));
        write_reg(REG_OUT_SIZE, DATA_W'(c.size));
        write_reg(REG_BOX_PRESENT, DATA_W'(c.present));
        write_reg(REG_BOX_LEFT, DATA_W'(c.left));
        write_reg(REG_BOX_BOTTOM, DATA_W'(c.bottom));
        write_reg(REG_BOX_RIGHT, DATA_W'(c.right));
        write_reg(REG_BOX_TOP, DATA_W'(c.top));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_now = c;
    endtask

    task automatic send_coord(input logic [COL_W-1:0] c, input logic [COL_W-1:0] r,
                              input logic typed, input addr_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coord_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coord_ch.valid <= 1'b1;
        coord_ch.out_col <= c;
        coord_ch.out_row <= r;
        do
            @(posedge clk);
        while (!coord_ch.ready);
        pending_addrs.push_back(typed ? want : crop_scale_addr(c, r));
    endtask

    initial
    begin : result_side
        addr_word_t want;
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_ch.valid && result_ch.ready)
                begin
                    if (pending_addrs.size() == 0)
                        report_mismatch("word with nothing pending, source_index",
                                        result_ch.source_index, 0);
                    else
                    begin
                        want = pending_addrs.pop_front();
                        if (result_ch.source_index !== want.source_index)
                            report_mismatch("source_index", result_ch.source_index,
                                            want.source_index);
                        if (result_ch.dest_index !== want.dest_index)
                            report_mismatch("dest_index", result_ch.dest_index,
                                            want.dest_index);
                        if (result_ch.copy_pixel !== want.copy_pixel)
                            report_mismatch("copy_pixel", result_ch.copy_pixel,
                                            want.copy_pixel);
                    end
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    result_ch.ready <= 1'b0;
                end
                else if (holds_done != hold_requests)
                begin
                    holds_done++;
                    hold_left = LONG_HOLD - 1;
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((coord_ch.valid && coord_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (psel && penable && pwrite && pready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        crop_cfg_t dcfg [0:6];
        int cur_sel;
        int n_eff;
        logic [COL_W-1:0] c;
        logic [COL_W-1:0] r;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coord_ch.valid = 1'b0;
        coord_ch.out_col = '0;
        coord_ch.out_row = '0;
        cfg_now = '{13'd4096, 13'd4096, 9'd64, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0};
        dcfg[0] = cfg_now;
        // full-image square box
        dcfg[1] = '{13'd4096, 13'd4096, 9'd256, 1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095};
        // wide box, growth clamped at the bottom edge
        dcfg[2] = '{13'd1000, 13'd1000, 9'd100, 1'b1, 12'd100, 12'd10, 12'd900, 12'd50};
        // tall box, growth clamped at the right edge
        dcfg[3] = '{13'd1000, 13'd1000, 9'd100, 1'b1, 12'd950, 12'd0, 12'd990, 12'd800};
        // inverted box, zero step
        dcfg[4] = '{13'd640, 13'd480, 9'd32, 1'b1, 12'd500, 12'd300, 12'd100, 12'd200};
        // saturated step, oversize dims, zero out_size
        dcfg[5] = '{13'd8191, 13'd8191, 9'd0, 1'b1, 12'd0, 12'd1000, 12'd4095, 12'd1000};
        // zero-width image, out_size above max
        dcfg[6] = '{13'd0, 13'd1, 9'd511, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 75;
        cur_sel = 0;
        foreach (DIRECTED_ROWS[i])
        begin
            if (int'(DIRECTED_ROWS[i].cfg_sel) != cur_sel)
            begin
                cur_sel = DIRECTED_ROWS[i].cfg_sel;
                load_crop(dcfg[cur_sel]);
            end
            send_coord(DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].row,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_crop(random_crop());
            case (ph / 4)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_requests++;
            n_eff = int'(eff_dim(cfg_now.size, MAX_OUT));
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    c = COL_W'($urandom_range(n_eff - 1));
                    r = COL_W'($urandom_range(n_eff - 1));
                end
                else
                begin
                    c = COL_W'($urandom);
                    r = COL_W'($urandom);
                end
                send_coord(c, r, 1'b0, '0);
            end
        end
        coord_ch.valid <= 1'b0;

        while (pending_addrs.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
